// ===== sv/asf_pkg.sv =====
// Shared constants and types for the 3D arrive steering force pipeline.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package asf_pkg;
	localparam int FRAC_BITS   = 8;
	localparam int COORD_W     = 32;
	localparam int DIFF_W      = 33;
	localparam int SQ_W        = 66;
	localparam int ROOT_W      = 34;
	localparam int REM_W       = 36;
	localparam int DEC_W       = 16;
	localparam int WGT_W       = 16;
	localparam int RAD_W       = 31;
	localparam int SPD_W       = 31;
	localparam int NUM1_W      = ROOT_W + FRAC_BITS;
	localparam int PROD_W      = DIFF_W + SPD_W;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 31;
	localparam int SQRT_LAT    = ROOT_W;
	localparam int LATENCY     = 3 + SQRT_LAT + 1 + NUM1_W + 2 + SPD_W + 3;

	localparam logic [CFG_IDX_W-1:0] REG_DECEL  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;

	typedef struct packed {
		logic                        near;
		logic [2:0][DIFF_W-1:0]      d;
		logic [2:0][COORD_W-1:0]     v;
		logic [SPD_W-1:0]            maxs;
	} sb_t;
endpackage
`default_nettype wire

// ===== sv/asf_sqrt.sv =====
// Pipelined floor square root, one result bit per register stage.
// Depends on asf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module asf_sqrt (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_vld,
	input  wire logic [asf_pkg::SQ_W-1:0]   rad,
	output logic                            out_vld,
	output logic [asf_pkg::ROOT_W-1:0]      root
);
	import asf_pkg::*;

	localparam int PAD_W = 2 * ROOT_W;

	logic              vld_s  [0:ROOT_W];
	logic [PAD_W-1:0]  rad_s  [0:ROOT_W];
	logic [REM_W-1:0]  rem_s  [0:ROOT_W];
	logic [ROOT_W-1:0] root_s [0:ROOT_W];

	assign vld_s[0]  = in_vld;
	assign rad_s[0]  = {{(PAD_W-SQ_W){1'b0}}, rad};
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_step
		logic [REM_W+1:0] rs;
		logic [REM_W+1:0] tr;
		logic [REM_W+1:0] df;
		assign rs = {rem_s[k], rad_s[k][PAD_W-1-2*k -: 2]};
		assign tr = {2'b00, root_s[k], 2'b01};
		assign df = rs - tr;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rad_s[k+1] <= rad_s[k];
			if (rs >= tr) begin
				rem_s[k+1]  <= df[REM_W-1:0];
				root_s[k+1] <= {root_s[k][ROOT_W-2:0], 1'b1};
			end else begin
				rem_s[k+1]  <= rs[REM_W-1:0];
				root_s[k+1] <= {root_s[k][ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign out_vld = vld_s[ROOT_W];
	assign root    = root_s[ROOT_W];
endmodule
`default_nettype wire

// ===== sv/arrive_steering_force_3d.sv =====
// Top level of the 3D arrive steering force pipeline.
// Depends on asf_pkg and asf_sqrt.
// Throughput: one agent per cycle; busy is always low, the pipeline never stalls.
// Length, speed and per-axis divisions are pipelined one bit per stage and set the depth.
// Reset clears the valid bits and the result ports and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
module arrive_steering_force_3d (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic signed [31:0]              pos_x,
	input  wire logic signed [31:0]              pos_y,
	input  wire logic signed [31:0]              pos_z,
	input  wire logic signed [31:0]              target_x,
	input  wire logic signed [31:0]              target_y,
	input  wire logic signed [31:0]              target_z,
	input  wire logic signed [31:0]              vel_x,
	input  wire logic signed [31:0]              vel_y,
	input  wire logic signed [31:0]              vel_z,
	input  wire logic [30:0]                     max_speed,
	input  wire logic                            cfg_we,
	input  wire logic [asf_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  wire logic [asf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output logic                                 done,
	output logic signed [31:0]                   steer_x,
	output logic signed [31:0]                   steer_y,
	output logic signed [31:0]                   steer_z
);
	import asf_pkg::*;

	localparam int D2_N = SPD_W;
	localparam int D2_R = ROOT_W;

	logic [DEC_W-1:0] decel_q;
	logic [WGT_W-1:0] weight_q;
	logic [RAD_W-1:0] radius_q;
	logic [DEC_W-1:0] dec_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decel_q  <= 16'd768;
			weight_q <= 16'd256;
			radius_q <= 31'd5120;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_DECEL:  decel_q  <= cfg_wdata[DEC_W-1:0];
				REG_WEIGHT: weight_q <= cfg_wdata[WGT_W-1:0];
				REG_RADIUS: radius_q <= cfg_wdata[RAD_W-1:0];
				default:    ;
			endcase
		end
	end

	assign dec_eff = (decel_q == '0) ? {{(DEC_W-1){1'b0}}, 1'b1} : decel_q;
	assign busy    = 1'b0;

	logic [COORD_W-1:0] pos_a [0:2];
	logic [COORD_W-1:0] tgt_a [0:2];
	logic [COORD_W-1:0] vel_a [0:2];
	assign pos_a[0] = pos_x;    assign pos_a[1] = pos_y;    assign pos_a[2] = pos_z;
	assign tgt_a[0] = target_x; assign tgt_a[1] = target_y; assign tgt_a[2] = target_z;
	assign vel_a[0] = vel_x;    assign vel_a[1] = vel_y;    assign vel_a[2] = vel_z;

	// Stages 1 to 3: difference, squares, sum of squares.
	logic            vld_s1, vld_s2, vld_s3;
	sb_t             sb_in;
	sb_t             sb_s1, sb_s2, sb_s3;
	logic [SQ_W-1:0] sq_s2 [0:2];
	logic [SQ_W-1:0] rad_s3;
	logic [SQ_W+1:0] sq_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_comb begin
		sb_in.near = 1'b0;
		sb_in.maxs = max_speed;
		for (int i = 0; i < 3; i++) begin
			sb_in.d[i] = {tgt_a[i][COORD_W-1], tgt_a[i]} - {pos_a[i][COORD_W-1], pos_a[i]};
			sb_in.v[i] = vel_a[i];
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_front
		logic [DIFF_W-1:0] a;
		assign a = sb_s1.d[i][DIFF_W-1] ? (~sb_s1.d[i] + 1'b1) : sb_s1.d[i];
		always_ff @(posedge clk) begin
			sq_s2[i] <= a * a;
		end
	end

	assign sq_sum = {2'b00, sq_s2[0]} + {2'b00, sq_s2[1]} + {2'b00, sq_s2[2]};

	always_ff @(posedge clk) begin
		sb_s1  <= sb_in;
		sb_s2  <= sb_s1;
		sb_s3  <= sb_s2;
		rad_s3 <= sq_sum[SQ_W-1:0];
	end

	// Square root with the sideband delayed alongside.
	logic              sq_vld;
	logic [ROOT_W-1:0] sq_root;
	sb_t               sbd [0:SQRT_LAT];

	asf_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s3),
		.rad     (rad_s3),
		.out_vld (sq_vld),
		.root    (sq_root)
	);

	assign sbd[0] = sb_s3;
	for (genvar k = 0; k < SQRT_LAT; k++) begin : g_sbd
		always_ff @(posedge clk) begin
			sbd[k+1] <= sbd[k];
		end
	end

	// Stage 4: stop radius compare.
	logic              vld_s4;
	logic [ROOT_W-1:0] len_s4;
	sb_t               sb_sq;
	sb_t               sb_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= sq_vld;
		end
	end

	always_comb begin
		sb_sq      = sbd[SQRT_LAT];
		sb_sq.near = sq_root <= {{(ROOT_W-RAD_W){1'b0}}, radius_q};
	end

	always_ff @(posedge clk) begin
		len_s4 <= sq_root;
		sb_s4  <= sb_sq;
	end

	// Speed division: (len << FRAC_BITS) / deceleration, one bit per stage.
	logic              d1_vld [0:NUM1_W];
	logic [DEC_W-1:0]  d1_rem [0:NUM1_W];
	logic [NUM1_W-1:0] d1_q   [0:NUM1_W];
	logic [ROOT_W-1:0] d1_len [0:NUM1_W];
	sb_t               d1_sb  [0:NUM1_W];

	assign d1_vld[0] = vld_s4;
	assign d1_rem[0] = '0;
	assign d1_q[0]   = '0;
	assign d1_len[0] = len_s4;
	assign d1_sb[0]  = sb_s4;

	for (genvar k = 0; k < NUM1_W; k++) begin : g_div1
		logic [NUM1_W-1:0] num;
		logic [DEC_W:0]    rs;
		logic [DEC_W:0]    df;
		assign num = {d1_len[k], {FRAC_BITS{1'b0}}};
		assign rs  = {d1_rem[k], num[NUM1_W-1-k]};
		assign df  = rs - {1'b0, dec_eff};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				d1_vld[k+1] <= 1'b0;
			end else begin
				d1_vld[k+1] <= d1_vld[k];
			end
		end

		always_ff @(posedge clk) begin
			d1_len[k+1] <= d1_len[k];
			d1_sb[k+1]  <= d1_sb[k];
			if (rs >= {1'b0, dec_eff}) begin
				d1_rem[k+1] <= df[DEC_W-1:0];
				d1_q[k+1]   <= {d1_q[k][NUM1_W-2:0], 1'b1};
			end else begin
				d1_rem[k+1] <= rs[DEC_W-1:0];
				d1_q[k+1]   <= {d1_q[k][NUM1_W-2:0], 1'b0};
			end
		end
	end

	// Stage 5: clamp to max speed. Stage 6: per-axis products.
	logic              vld_s5, vld_s6;
	logic [SPD_W-1:0]  speed_s5;
	logic [ROOT_W-1:0] len_s5, len_s6;
	sb_t               sb_s5, sb_s6;
	logic [PROD_W-1:0] prod_s6 [0:2];
	logic [NUM1_W-1:0] q_fin;

	assign q_fin = d1_q[NUM1_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s5 <= d1_vld[NUM1_W];
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		len_s5 <= d1_len[NUM1_W];
		sb_s5  <= d1_sb[NUM1_W];
		if (q_fin > {{(NUM1_W-SPD_W){1'b0}}, d1_sb[NUM1_W].maxs}) begin
			speed_s5 <= d1_sb[NUM1_W].maxs;
		end else begin
			speed_s5 <= q_fin[SPD_W-1:0];
		end
		len_s6 <= len_s5;
		sb_s6  <= sb_s5;
	end

	for (genvar i = 0; i < 3; i++) begin : g_prod
		logic [DIFF_W-1:0] a;
		assign a = sb_s5.d[i][DIFF_W-1] ? (~sb_s5.d[i] + 1'b1) : sb_s5.d[i];
		always_ff @(posedge clk) begin
			prod_s6[i] <= a * speed_s5;
		end
	end

	// Per-axis division by the length; the quotient does not exceed the speed unless the length is zero.
	logic              d2_vld [0:D2_N];
	logic [ROOT_W-1:0] d2_len [0:D2_N];
	sb_t               d2_sb  [0:D2_N];
	logic [D2_R-1:0]   d2_rem [0:2][0:D2_N];
	logic [SPD_W-1:0]  d2_q   [0:2][0:D2_N];
	logic [SPD_W-1:0]  d2_lo  [0:2][0:D2_N];

	assign d2_vld[0] = vld_s6;
	assign d2_len[0] = len_s6;
	assign d2_sb[0]  = sb_s6;

	for (genvar k = 0; k < D2_N; k++) begin : g_div2_ctl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				d2_vld[k+1] <= 1'b0;
			end else begin
				d2_vld[k+1] <= d2_vld[k];
			end
		end
		always_ff @(posedge clk) begin
			d2_len[k+1] <= d2_len[k];
			d2_sb[k+1]  <= d2_sb[k];
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_div2
		assign d2_rem[i][0] = {1'b0, prod_s6[i][PROD_W-1:SPD_W]};
		assign d2_q[i][0]   = '0;
		assign d2_lo[i][0]  = prod_s6[i][SPD_W-1:0];
		for (genvar k = 0; k < D2_N; k++) begin : g_step
			logic [D2_R:0] rs;
			logic [D2_R:0] df;
			assign rs = {d2_rem[i][k], d2_lo[i][k][SPD_W-1-k]};
			assign df = rs - {1'b0, d2_len[k]};
			always_ff @(posedge clk) begin
				d2_lo[i][k+1] <= d2_lo[i][k];
				if (rs >= {1'b0, d2_len[k]}) begin
					d2_rem[i][k+1] <= df[D2_R-1:0];
					d2_q[i][k+1]   <= {d2_q[i][k][SPD_W-2:0], 1'b1};
				end else begin
					d2_rem[i][k+1] <= rs[D2_R-1:0];
					d2_q[i][k+1]   <= {d2_q[i][k][SPD_W-2:0], 1'b0};
				end
			end
		end
	end

	// Stage 7: minus velocity. Stage 8: weight. Stage 9: shift and saturate.
	logic                       vld_s7, vld_s8;
	logic                       near_s7, near_s8;
	logic [DIFF_W-1:0]          s_s7   [0:2];
	logic [DIFF_W+WGT_W-1:0]    pm_s8  [0:2];
	logic                       neg_s8 [0:2];
	logic [COORD_W-1:0]         res    [0:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s7 <= d2_vld[D2_N];
			vld_s8 <= vld_s7;
			done   <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		near_s7 <= d2_sb[D2_N].near;
		near_s8 <= near_s7;
	end

	for (genvar i = 0; i < 3; i++) begin : g_back
		logic [DIFF_W-1:0]             mag;
		logic [DIFF_W-1:0]             des;
		logic [DIFF_W-1:0]             a;
		logic [DIFF_W+WGT_W-FRAC_BITS-1:0] sh;
		assign mag = {{(DIFF_W-SPD_W){1'b0}}, d2_q[i][D2_N]};
		assign des = d2_sb[D2_N].d[i][DIFF_W-1] ? (~mag + 1'b1) : mag;
		assign a   = s_s7[i][DIFF_W-1] ? (~s_s7[i] + 1'b1) : s_s7[i];
		assign sh  = pm_s8[i][DIFF_W+WGT_W-1:FRAC_BITS];

		always_ff @(posedge clk) begin
			s_s7[i]   <= des - {d2_sb[D2_N].v[i][COORD_W-1], d2_sb[D2_N].v[i]};
			pm_s8[i]  <= a * weight_q;
			neg_s8[i] <= s_s7[i][DIFF_W-1];
		end

		always_comb begin
			if (near_s8) begin
				res[i] = '0;
			end else if (!neg_s8[i]) begin
				if (sh > {{(DIFF_W+WGT_W-FRAC_BITS-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}})
					res[i] = {1'b0, {(COORD_W-1){1'b1}}};
				else
					res[i] = sh[COORD_W-1:0];
			end else begin
				if (sh > {{(DIFF_W+WGT_W-FRAC_BITS-COORD_W){1'b0}}, 1'b1,
						{(COORD_W-1){1'b0}}})
					res[i] = {1'b1, {(COORD_W-1){1'b0}}};
				else
					res[i] = ~sh[COORD_W-1:0] + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steer_x <= '0;
			steer_y <= '0;
			steer_z <= '0;
		end else if (vld_s8) begin
			steer_x <= res[0];
			steer_y <= res[1];
			steer_z <= res[2];
		end
	end
endmodule
`default_nettype wire

// ===== sv/asf_checker.sv =====
// Port-level checks for the 3D arrive steering force pipeline, bound to the top level.
// Depends on asf_pkg and arrive_steering_force_3d.
`timescale 1ns / 1ps
`default_nettype none
module asf_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [31:0] steer_x
);
	import asf_pkg::*;

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_start_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("transfer without result");

	a_done_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result without transfer");

	a_quiet_result: assert property (@(posedge clk) disable iff (!arst_n)
		!done && !$past(done) |-> $stable(steer_x))
		else $error("result changed without strobe");
endmodule

bind arrive_steering_force_3d asf_checker u_asf_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.done    (done),
	.steer_x (steer_x)
);
`default_nettype wire
